@@ rtl/lsa_pkg.sv @@
package lsa_pkg;

   localparam int MAX_BLOCKS = 64;
   localparam int CNT_W      = $clog2(MAX_BLOCKS);
   localparam int ADDR_W     = 48;
   localparam int OFF_W      = 32;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 4;

   // block_count limit for a push
   localparam logic [CNT_W-1:0] PUSH_LIMIT = CNT_W'(MAX_BLOCKS - 2);

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_SIZE    = CSR_IDX_W'(1);

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } lsa_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NO_MEMORY = 3'd1,
      ST_NO_BLOCKS = 3'd2,
      ST_NOT_TOP   = 3'd3,
      ST_UNDERFLOW = 3'd4
   } lsa_status_type;

   // controller -> datapath
   typedef struct packed {
      logic exec;      // accept word and update allocator state
      logic pop_load;  // reload cached next-to-top offset from memory
      logic rsp_load;  // load the result register
   } lsa_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic pop;       // accepted word is a free that pops a block
      logic rsp_free;  // result register can take a new word
   } lsa_sts_type;

endpackage

@@ rtl/lsa_ctrl.sv @@
module lsa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lsa_pkg::lsa_sts_type sts,
   output lsa_pkg::lsa_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_POP  = 3'b010,
      S_RESP = 3'b100
   } lsa_state_type;

   lsa_state_type state_ff;
   lsa_state_type state_in;

   always_comb begin
      req_stall    = (state_ff != S_IDLE);
      cmd.exec     = (state_ff == S_IDLE) && req_valid;
      cmd.pop_load = (state_ff == S_POP);
      cmd.rsp_load = (state_ff == S_RESP) && sts.rsp_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = sts.pop ? S_POP : S_RESP;
            end
         end
         S_POP: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // one word in flight: an accept is always followed by a stall
   a_single_word: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("word accepted while previous one in flight");

   // a pop goes through the reload step before the result
   a_pop_reload: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && sts.pop) |=> (cmd.pop_load && !cmd.rsp_load))
      else $error("pop skipped the offset reload");

endmodule

@@ rtl/lsa_datapath.sv @@
module lsa_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  lsa_pkg::lsa_cmd_type          cmd,
   output lsa_pkg::lsa_sts_type          sts,
   input  logic                          csr_valid,
   input  logic [lsa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lsa_pkg::ADDR_W-1:0]    csr_data,
   input  logic [lsa_pkg::OP_W-1:0]      req_opcode,
   input  logic [lsa_pkg::OFF_W-1:0]     req_request_size,
   input  logic [lsa_pkg::ADDR_W-1:0]    req_free_address,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lsa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [lsa_pkg::ADDR_W-1:0]    rsp_block_address,
   output logic [lsa_pkg::OFF_W-1:0]     rsp_top_block_size,
   output logic [lsa_pkg::OFF_W-1:0]     rsp_allocated_amount,
   output logic [lsa_pkg::OFF_W-1:0]     rsp_live_allocations,
   output logic [lsa_pkg::OFF_W-1:0]     rsp_frame_allocations
);

   localparam int ADDR_W = lsa_pkg::ADDR_W;
   localparam int OFF_W  = lsa_pkg::OFF_W;
   localparam int CNT_W  = lsa_pkg::CNT_W;

   // end offset stack; entry 0 is never written, and the pop reload uses zero in its place
   logic [OFF_W-1:0] mem [lsa_pkg::MAX_BLOCKS];
   logic [OFF_W-1:0] rd_data_ff;
   logic             mem_we;
   logic [CNT_W-1:0] mem_waddr;
   logic [CNT_W-1:0] mem_raddr;

   logic [ADDR_W-1:0] base_ff, base_in;
   logic [OFF_W-1:0]  pool_ff, pool_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [OFF_W-1:0]  top_ff, top_in;      // end_offsets[count]
   logic [OFF_W-1:0]  below_ff, below_in;  // end_offsets[count-1]
   logic [OFF_W-1:0]  live_ff, live_in;
   logic [OFF_W-1:0]  frame_ff, frame_in;

   logic [lsa_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [ADDR_W-1:0]            addr_ff, addr_in;
   logic [OFF_W-1:0]             frame_out_ff, frame_out_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lsa_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [ADDR_W-1:0]             rsp_addr_ff;
   logic [OFF_W-1:0]              rsp_top_size_ff;
   logic [OFF_W-1:0]              rsp_alloc_ff;
   logic [OFF_W-1:0]              rsp_live_ff;
   logic [OFF_W-1:0]              rsp_frame_ff;

   logic [OFF_W:0]    sum;
   logic              fits;
   logic              room;
   logic [ADDR_W-1:0] alloc_addr;
   logic [ADDR_W-1:0] free_expect;

   always_comb begin
      sum         = {1'b0, top_ff} + {1'b0, req_request_size};
      fits        = sum < {1'b0, pool_ff};
      room        = count_ff < lsa_pkg::PUSH_LIMIT;
      alloc_addr  = base_ff + ADDR_W'(top_ff);
      free_expect = base_ff + ADDR_W'(below_ff);
   end

   always_comb begin
      sts.pop      = (req_opcode == lsa_pkg::OP_FREE) && (count_ff != '0);
      sts.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   // configuration
   always_comb begin
      base_in = base_ff;
      pool_in = pool_ff;
      if (csr_valid) begin
         if (csr_index == lsa_pkg::CSR_BASE_ADDRESS) begin
            base_in = csr_data;
         end else if (csr_index == lsa_pkg::CSR_POOL_SIZE) begin
            pool_in = csr_data[OFF_W-1:0];
         end
      end
   end

   // allocator state update
   always_comb begin
      count_in     = count_ff;
      top_in       = top_ff;
      below_in     = below_ff;
      live_in      = live_ff;
      frame_in     = frame_ff;
      status_in    = status_ff;
      addr_in      = addr_ff;
      frame_out_in = frame_out_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff + CNT_W'(1);
      mem_raddr    = count_ff - CNT_W'(2);
      if (cmd.exec) begin
         status_in    = lsa_pkg::ST_OK;
         addr_in      = '0;
         frame_out_in = frame_ff;
         case (req_opcode)
            lsa_pkg::OP_ALLOC: begin
               live_in      = live_ff + OFF_W'(1);
               frame_in     = frame_ff + OFF_W'(1);
               frame_out_in = frame_ff + OFF_W'(1);
               if (fits && room) begin
                  count_in = count_ff + CNT_W'(1);
                  below_in = top_ff;
                  top_in   = sum[OFF_W-1:0];
                  mem_we   = 1'b1;
                  addr_in  = alloc_addr;
               end else if (!fits) begin
                  status_in = lsa_pkg::ST_NO_MEMORY;
               end else begin
                  status_in = lsa_pkg::ST_NO_BLOCKS;
               end
            end
            lsa_pkg::OP_FREE: begin
               live_in = live_ff - OFF_W'(1);
               if (count_ff != '0) begin
                  count_in = count_ff - CNT_W'(1);
                  top_in   = below_ff;
                  if (req_free_address != free_expect) begin
                     status_in = lsa_pkg::ST_NOT_TOP;
                  end
               end else begin
                  status_in = lsa_pkg::ST_UNDERFLOW;
               end
            end
            lsa_pkg::OP_CLEAR: begin
               frame_in = '0;
            end
            default: begin
            end
         endcase
      end
      if (cmd.pop_load) begin
         // count already popped; entry 0 is the pool start
         below_in = (count_ff <= CNT_W'(1)) ? '0 : rd_data_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= sum[OFF_W-1:0];
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         pool_ff      <= '0;
         count_ff     <= '0;
         top_ff       <= '0;
         below_ff     <= '0;
         live_ff      <= '0;
         frame_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         pool_ff      <= pool_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         below_ff     <= below_in;
         live_ff      <= live_in;
         frame_ff     <= frame_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      addr_ff      <= addr_in;
      frame_out_ff <= frame_out_in;
      if (cmd.rsp_load) begin
         rsp_status_ff   <= status_ff;
         rsp_addr_ff     <= addr_ff;
         rsp_top_size_ff <= (count_ff == '0) ? '0 : top_ff - below_ff;
         rsp_alloc_ff    <= top_ff;
         rsp_live_ff     <= live_ff;
         rsp_frame_ff    <= frame_out_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_block_address     = rsp_addr_ff;
   assign rsp_top_block_size    = rsp_top_size_ff;
   assign rsp_allocated_amount  = rsp_alloc_ff;
   assign rsp_live_allocations  = rsp_live_ff;
   assign rsp_frame_allocations = rsp_frame_ff;

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lsa_pkg::PUSH_LIMIT)
      else $error("block count beyond stack limit");

   a_top_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0 && !cmd.pop_load) |-> (top_ff >= below_ff))
      else $error("cached top offset below next-to-top offset");

   a_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while held");

endmodule

@@ rtl/lifo_stack_allocator.sv @@
// LIFO bump allocator over one pool at csr base_address (index 0) of csr pool_size
// bytes (index 1). Each request word is an allocate, a free of the top block, a
// read-and-clear of the frame count or a nop, and yields exactly one response word.
// A free that pops a block passes through a reload state, where the registered read
// of the offset stack memory refills the cached next-to-top offset, before the load
// of the response; every other word goes straight to the response load. A new
// request is taken once the previous response is loaded into the output register, and
// that load waits while a held response is stalled. The stack holds up to
// MAX_BLOCKS-2 blocks. Config writes are always ready and must be issued while idle.
module lifo_stack_allocator (
   input  logic                          clock,
   input  logic                          reset,
   // config write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lsa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lsa_pkg::ADDR_W-1:0]    csr_data,
   // request word
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lsa_pkg::OP_W-1:0]      req_opcode,
   input  logic [lsa_pkg::OFF_W-1:0]     req_request_size,
   input  logic [lsa_pkg::ADDR_W-1:0]    req_free_address,
   // response word
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lsa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [lsa_pkg::ADDR_W-1:0]    rsp_block_address,
   output logic [lsa_pkg::OFF_W-1:0]     rsp_top_block_size,
   output logic [lsa_pkg::OFF_W-1:0]     rsp_allocated_amount,
   output logic [lsa_pkg::OFF_W-1:0]     rsp_live_allocations,
   output logic [lsa_pkg::OFF_W-1:0]     rsp_frame_allocations
);

   lsa_pkg::lsa_cmd_type cmd;
   lsa_pkg::lsa_sts_type sts;

   // registers take writes in any cycle
   assign csr_ready = 1'b1;

   // sequencing: accept/execute, optional offset reload, response load
   lsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // allocator state, cached top offsets, offset stack memory, result register
   lsa_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .csr_valid             (csr_valid && csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .req_opcode            (req_opcode),
      .req_request_size      (req_request_size),
      .req_free_address      (req_free_address),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_block_address     (rsp_block_address),
      .rsp_top_block_size    (rsp_top_block_size),
      .rsp_allocated_amount  (rsp_allocated_amount),
      .rsp_live_allocations  (rsp_live_allocations),
      .rsp_frame_allocations (rsp_frame_allocations)
   );

endmodule
